// ===== src/vkd_pkg.sv =====
// vkd_pkg: shared types, codes and the threshold table for the vox keying detector
// no dependencies
`default_nettype none

package vkd_pkg;

    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned SEL_W      = 4;
    localparam int unsigned HANG_W     = 10;
    localparam int unsigned BAR_W      = 7;
    localparam int unsigned THRESH_W   = 9;
    localparam int unsigned HANG_SHIFT = 6;
    localparam int unsigned CLIP_W     = 13;
    localparam int unsigned RECIP_W    = 13;
    localparam int unsigned PROD_W     = CLIP_W + RECIP_W;
    localparam int unsigned RECIP_SH   = 18;

    localparam logic [MODE_W-1:0]   MODE_QUIET    = 2'd0;
    localparam logic [MODE_W-1:0]   MODE_TX       = 2'd1;

    localparam logic [THRESH_W-1:0] ON_OFFSET     = 9'd150;
    localparam logic [THRESH_W-1:0] OFF_OFFSET    = 9'd145;
    localparam logic [COUNT_W-1:0]  ATTACK_TICKS  = 16'd4;
    localparam logic [CLIP_W-1:0]   BAR_MAX       = 13'd5000;
    localparam logic [RECIP_W-1:0]  BAR_RECIP     = 13'd5243;
    localparam logic [SEL_W-1:0]    SEL_MAX       = 4'd9;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic        REG_LEVEL_SELECT = 1'b0;
    localparam logic        REG_HANG_DELAY   = 1'b1;

    typedef struct packed {
        logic             start_tx;
        logic             end_tx;
        logic             bar_valid;
        logic [BAR_W-1:0] bar_value;
        logic             keyed;
    } t_result;

    function automatic logic [THRESH_W-1:0] thresh_base(input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] idx;
        logic [THRESH_W-1:0] base;
        idx = (sel > SEL_MAX) ? SEL_MAX : sel;
        case (idx)
            4'd0:    base = 9'h000;
            4'd1:    base = 9'h002;
            4'd2:    base = 9'h004;
            4'd3:    base = 9'h006;
            4'd4:    base = 9'h00A;
            4'd5:    base = 9'h03C;
            4'd6:    base = 9'h06E;
            4'd7:    base = 9'h0A0;
            4'd8:    base = 9'h0D2;
            default: base = 9'h104;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== src/vkd_meter.sv =====
// vkd_meter: meter bar value, level clipped at 5000 then divided by 50
// depends on vkd_pkg
`default_nettype none

module vkd_meter
    import vkd_pkg::*;
(
    input  wire logic [LEVEL_W-1:0] i_level,
    output logic      [BAR_W-1:0]   o_bar_value
);

    logic [CLIP_W-1:0] clipped;
    logic [PROD_W-1:0] prod;

    // divide by 50 through the reciprocal 5243/262144, exact up to 5000
    always_comb begin
        clipped = (i_level > LEVEL_W'(BAR_MAX)) ? BAR_MAX : i_level[CLIP_W-1:0];
        prod    = PROD_W'(clipped) * PROD_W'(BAR_RECIP);
    end

    assign o_bar_value = prod[RECIP_SH +: BAR_W];

endmodule

`default_nettype wire

// ===== src/vkd_core.sv =====
// vkd_core: hysteresis compare, attack and hang counter, keyed state
// depends on vkd_pkg
`default_nettype none

module vkd_core
    import vkd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire logic [LEVEL_W-1:0] i_level,
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire logic               i_gate,
    input  wire logic [SEL_W-1:0]   i_level_select,
    input  wire logic [HANG_W-1:0]  i_hang_delay,
    input  wire logic [BAR_W-1:0]   i_bar_value,
    output t_result                 o_result
);

    logic               r_keyed;
    logic               n_keyed;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    logic [THRESH_W-1:0] base;
    logic [LEVEL_W-1:0]  on_level;
    logic [LEVEL_W-1:0]  off_level;
    logic                voiced;
    logic                start_tx;
    logic                end_tx;
    logic                bar_valid;

    always_comb begin
        base      = thresh_base(i_level_select);
        on_level  = LEVEL_W'(base) + LEVEL_W'(ON_OFFSET);
        off_level = LEVEL_W'(base) + LEVEL_W'(OFF_OFFSET);
        if (i_level >= on_level) begin
            voiced = 1'b1;
        end else if (i_level <= off_level) begin
            voiced = 1'b0;
        end else begin
            voiced = r_keyed;
        end

        n_keyed   = r_keyed;
        n_count   = r_count;
        start_tx  = 1'b0;
        end_tx    = 1'b0;
        bar_valid = 1'b0;
        if (i_gate) begin
            if (!voiced || i_mode != MODE_QUIET) begin
                if (!voiced && i_mode == MODE_TX) begin
                    // hang timing while transmitting in silence
                    n_count   = r_count + COUNT_W'(1);
                    bar_valid = 1'b1;
                    if (r_count[COUNT_W-1:HANG_SHIFT] >= i_hang_delay) begin
                        n_keyed = 1'b0;
                        n_count = '0;
                        end_tx  = 1'b1;
                    end
                end else begin
                    bar_valid = r_keyed;
                    n_count   = '0;
                end
            end else begin
                // attack qualification while quiet
                n_count = r_count + COUNT_W'(1);
                if (r_count > ATTACK_TICKS) begin
                    n_keyed  = 1'b1;
                    start_tx = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyed <= 1'b0;
            r_count <= '0;
        end else if (i_advance) begin
            r_keyed <= n_keyed;
            r_count <= n_count;
        end
    end

    assign o_result = '{
        start_tx:  start_tx,
        end_tx:    end_tx,
        bar_valid: bar_valid,
        bar_value: i_bar_value,
        keyed:     n_keyed
    };

endmodule

`default_nettype wire

// ===== src/vox_keying_detector_unit.sv =====
// vox_keying_detector_unit: top level, input register, result register, config port
// depends on vkd_pkg, vkd_meter, vkd_core
//
//   channel   handshake             beat
//   input     i_valid / o_stall     i_audio_level, i_radio_mode, i_gate_open
//   result    o_valid / i_stall     o_start_tx, o_end_tx, o_bar_valid, o_bar_value, o_keyed
//   config    psel/penable/pready   paddr, pwdata, pwrite, prdata
//
// one beat per cycle sustained unless stalled; input register first, then result register
// the keyed flag and tick counter update as a beat moves from the input to the result register
// a stalled result holds; while the result waits the input register takes a beat only if empty
// synchronous active-low reset clears control state, keyed flag, counter and config
`default_nettype none

module vox_keying_detector_unit
    import vkd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [LEVEL_W-1:0] i_audio_level,
    input  wire logic [MODE_W-1:0]  i_radio_mode,
    input  wire logic               i_gate_open,

    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_start_tx,
    output logic                    o_end_tx,
    output logic                    o_bar_valid,
    output logic      [BAR_W-1:0]   o_bar_value,
    output logic                    o_keyed,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready
);

    logic               sel_addr;
    logic [SEL_W-1:0]   r_sel;
    logic [HANG_W-1:0]  r_hang_delay;

    logic               r_in_vld;
    logic [LEVEL_W-1:0] r_in_level;
    logic [MODE_W-1:0]  r_in_mode;
    logic               r_in_gate;

    logic               r_out_vld;
    t_result            r_out;

    logic               advance;
    logic               accept;
    logic [BAR_W-1:0]   bar_value;
    t_result            result;

    assign pready = 1'b1;
    assign sel_addr = (paddr[2] == REG_LEVEL_SELECT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel        <= '0;
            r_hang_delay <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (sel_addr) begin
                r_sel <= pwdata[SEL_W-1:0];
            end else begin
                r_hang_delay <= pwdata[HANG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_HANG_DELAY) begin
            prdata = DATA_W'(r_hang_delay);
        end else begin
            prdata = DATA_W'(r_sel);
        end
    end

    assign advance = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_level <= i_audio_level;
            r_in_mode  <= i_radio_mode;
            r_in_gate  <= i_gate_open;
        end
    end

    vkd_meter u_meter (
        .i_level     (r_in_level),
        .o_bar_value (bar_value)
    );

    vkd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_level        (r_in_level),
        .i_mode         (r_in_mode),
        .i_gate         (r_in_gate),
        .i_level_select (r_sel),
        .i_hang_delay   (r_hang_delay),
        .i_bar_value    (bar_value),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_start_tx  = r_out.start_tx;
    assign o_end_tx    = r_out.end_tx;
    assign o_bar_valid = r_out.bar_valid;
    assign o_bar_value = r_out.bar_value;
    assign o_keyed     = r_out.keyed;

endmodule

`default_nettype wire

// ===== tb/sv/vox_keying_detector_unit_test.sv =====
// vox_keying_detector_unit_test: self-checking bench for the vox keying detector top level
// depends on vkd_pkg and vox_keying_detector_unit; drives ticks, predicts keying, checks beats
module vox_keying_detector_unit_test;
    import vkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_TICKS = 70;
    localparam int HOLD_CYCLES = 300;
    localparam int ON_MARGIN   = 150;
    localparam int OFF_MARGIN  = 145;
    localparam int ATTACK_LEN  = 4;
    localparam int HANG_DIV    = 64;
    localparam int BAR_CAP     = 5000;
    localparam int BAR_STEP    = 50;
    localparam int SENS_TOP    = 9;
    localparam int SENS_BASE [10] = '{0, 2, 4, 6, 10, 60, 110, 160, 210, 260};

    localparam logic [MODE_W-1:0] MODE_OTHER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int NUM_PHASES = 6;
    localparam int PH_SEL   [NUM_PHASES] = '{9, 15, 5, 12, 0, 7};
    localparam int PH_HANG  [NUM_PHASES] = '{1, 0, 2, 3, 1023, 1};
    localparam int PH_IDLE  [NUM_PHASES] = '{0, 69, 0, 37, 0, 37};
    localparam int PH_STALL [NUM_PHASES] = '{0, 0, 69, 37, 0, 37};

    typedef enum int {LV_VOICED, LV_SILENT, LV_BAND} t_level_kind;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [MODE_W-1:0]  mode;
        logic               gate;
        logic               literal;
        t_result            want;
    } t_row;

    localparam int NUM_ROWS = 22;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{16'd65535, MODE_SPARE, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 7'd100, 1'b0}},
        '{16'd0,     MODE_QUIET, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 7'd0,   1'b0}},
        '{16'd5000,  MODE_OTHER, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 7'd100, 1'b0}},
        '{16'd0,     MODE_TX,    1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 7'd0,   1'b0}},
        '{16'd147,   MODE_QUIET, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 7'd2,   1'b0}},
        '{16'd150,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd150,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd150,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd150,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd150,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd150,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd148,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd146,   MODE_TX,    1'b1, 1'b0, '0},
        '{16'd65535, MODE_QUIET, 1'b0, 1'b0, '0},
        '{16'd145,   MODE_TX,    1'b1, 1'b0, '0},
        '{16'd40000, MODE_SPARE, 1'b1, 1'b0, '0},
        '{16'd5001,  MODE_OTHER, 1'b1, 1'b0, '0},
        '{16'd4999,  MODE_OTHER, 1'b1, 1'b0, '0},
        '{16'd49,    MODE_OTHER, 1'b1, 1'b0, '0},
        '{16'd50,    MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd149,   MODE_QUIET, 1'b1, 1'b0, '0},
        '{16'd65535, MODE_QUIET, 1'b1, 1'b0, '0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [LEVEL_W-1:0] i_audio_level = '0;
    logic [MODE_W-1:0]  i_radio_mode = '0;
    logic               i_gate_open = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_start_tx;
    logic               o_end_tx;
    logic               o_bar_valid;
    logic [BAR_W-1:0]   o_bar_value;
    logic               o_keyed;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // predictor state and register mirror
    logic               keyed_now = 1'b0;
    logic [COUNT_W-1:0] tick_count_now = '0;
    logic [SEL_W-1:0]   sel_cfg = '0;
    logic [HANG_W-1:0]  hang_cfg = '0;

    t_result     pending_results [$];
    t_result     head_result;
    int unsigned ticks_sent = 0;
    int unsigned cycle_count = 0;
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    vox_keying_detector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_audio_level (i_audio_level),
        .i_radio_mode  (i_radio_mode),
        .i_gate_open   (i_gate_open),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_start_tx    (o_start_tx),
        .o_end_tx      (o_end_tx),
        .o_bar_valid   (o_bar_valid),
        .o_bar_value   (o_bar_value),
        .o_keyed       (o_keyed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        $display("mismatch %s: expected %0d got %0d", what, want_v, got_v);
        errors++;
    endtask

    function automatic int sens_base();
        return SENS_BASE[(sel_cfg > SENS_TOP) ? SENS_TOP : int'(sel_cfg)];
    endfunction

    function automatic t_result predict_tick(input logic [LEVEL_W-1:0] level,
                                             input logic [MODE_W-1:0] mode,
                                             input logic gate);
        t_result            r;
        logic               voice;
        logic [COUNT_W-1:0] prev;
        int                 base;
        int                 clip;
        r = '0;
        base = sens_base();
        clip = (level > BAR_CAP) ? BAR_CAP : int'(level);
        r.bar_value = BAR_W'(clip / BAR_STEP);
        if (gate) begin
            if (level >= base + ON_MARGIN) begin
                voice = 1'b1;
            end else if (level <= base + OFF_MARGIN) begin
                voice = 1'b0;
            end else begin
                voice = keyed_now;
            end
            prev = tick_count_now;
            if (!voice || mode != MODE_QUIET) begin
                if (!voice && mode == MODE_TX) begin
                    tick_count_now = tick_count_now + 1'b1;
                    if (int'(prev) / HANG_DIV >= int'(hang_cfg)) begin
                        keyed_now = 1'b0;
                        tick_count_now = '0;
                        r.end_tx = 1'b1;
                    end
                    r.bar_valid = 1'b1;
                end else begin
                    r.bar_valid = keyed_now;
                    tick_count_now = '0;
                end
            end else begin
                tick_count_now = tick_count_now + 1'b1;
                if (int'(prev) > ATTACK_LEN) begin
                    keyed_now = 1'b1;
                    r.start_tx = 1'b1;
                end
            end
        end
        r.keyed = keyed_now;
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level(input t_level_kind kind);
        int base;
        base = sens_base();
        case (kind)
            LV_VOICED: begin
                if ($urandom_range(1)) begin
                    return LEVEL_W'($urandom_range(base + ON_MARGIN + 10, base + ON_MARGIN));
                end
                return LEVEL_W'($urandom_range(65535, base + ON_MARGIN));
            end
            LV_SILENT: begin
                if ($urandom_range(1)) begin
                    return LEVEL_W'($urandom_range(base + OFF_MARGIN, base + OFF_MARGIN - 10));
                end
                return LEVEL_W'($urandom_range(base + OFF_MARGIN, 0));
            end
            default: begin
                return LEVEL_W'($urandom_range(base + ON_MARGIN - 1, base + OFF_MARGIN + 1));
            end
        endcase
    endfunction

    task automatic send_tick(input logic [LEVEL_W-1:0] level, input logic [MODE_W-1:0] mode,
                             input logic gate);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_audio_level <= level;
        i_radio_mode  <= mode;
        i_gate_open   <= gate;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_tick(level, mode, gate));
        if (gate) begin
            ticks_sent++;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wr ? val : '0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!wr && prdata != val) begin
            report_mismatch("register readback", int'(val), int'(prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int sel, input int hang);
        reg_access(1'b1, REG_LEVEL_SELECT, DATA_W'(sel));
        reg_access(1'b1, REG_HANG_DELAY, DATA_W'(hang));
        reg_access(1'b0, REG_LEVEL_SELECT, DATA_W'(sel));
        reg_access(1'b0, REG_HANG_DELAY, DATA_W'(hang));
        sel_cfg  = SEL_W'(sel);
        hang_cfg = HANG_W'(hang);
    endtask

    function automatic logic gate_mostly();
        return $urandom_range(15) != 0;
    endfunction

    // attack run, some voiced transmit ticks, then a silent hang run that usually releases
    task automatic talk_burst();
        int n;
        int k;
        n = $urandom_range(9, 2);
        for (k = 0; k < n; k++) begin
            send_tick(pick_level(($urandom_range(7) == 0) ? LV_BAND : LV_VOICED),
                      MODE_QUIET, gate_mostly());
        end
        n = $urandom_range(3, 0);
        for (k = 0; k < n; k++) begin
            send_tick(pick_level(LV_VOICED), ($urandom_range(3) == 0) ? MODE_OTHER : MODE_TX,
                      1'b1);
        end
        n = (hang_cfg <= 3) ? HANG_DIV * int'(hang_cfg) + $urandom_range(4, 1)
                            : $urandom_range(60, 1);
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(n, 1);
        end
        for (k = 0; k < n; k++) begin
            if ($urandom_range(63) == 0) begin
                send_tick(pick_level(LV_BAND), MODE_TX, 1'b1);
            end else begin
                send_tick(pick_level(LV_SILENT), MODE_TX, gate_mostly());
            end
        end
    endtask

    // result side: stall at random, or hold off for a long stretch on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 0, 1);
            end else begin
                head_result = pending_results.pop_front();
                if (o_start_tx !== head_result.start_tx) begin
                    report_mismatch("start_tx", int'(head_result.start_tx), int'(o_start_tx));
                end
                if (o_end_tx !== head_result.end_tx) begin
                    report_mismatch("end_tx", int'(head_result.end_tx), int'(o_end_tx));
                end
                if (o_bar_valid !== head_result.bar_valid) begin
                    report_mismatch("bar_valid", int'(head_result.bar_valid),
                                    int'(o_bar_valid));
                end
                if (o_bar_value !== head_result.bar_value) begin
                    report_mismatch("bar_value", int'(head_result.bar_value),
                                    int'(o_bar_value));
                end
                if (o_keyed !== head_result.keyed) begin
                    report_mismatch("keyed", int'(head_result.keyed), int'(o_keyed));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int          ph;
        int          r;
        int unsigned phase_base;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++) begin
            send_tick(DIRECTED[r].level, DIRECTED[r].mode, DIRECTED[r].gate);
            if (DIRECTED[r].literal) begin
                pending_results[pending_results.size() - 1] = DIRECTED[r].want;
            end
        end
        drain();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_config(PH_SEL[ph], PH_HANG[ph]);
            idle_pct  = PH_IDLE[ph];
            stall_pct = PH_STALL[ph];
            if (ph == 0) begin
                hold_req++;
            end
            phase_base = ticks_sent;
            while (ticks_sent - phase_base < PHASE_TICKS) begin
                if ($urandom_range(9) < 6) begin
                    talk_burst();
                end else begin
                    repeat ($urandom_range(6, 1)) begin
                        send_tick(LEVEL_W'($urandom_range(65535)), MODE_W'($urandom_range(3)),
                                  1'(($urandom_range(1))));
                    end
                end
            end
            drain();
        end

        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
